// ----- rtl/bkv_pkg.sv -----
// Shared types and constants of the binned key-value table.
`timescale 1ns / 1ps

package bkv_pkg;

  // Width of keys and values on the ports and in the store
  localparam int DATA_W = 32;

  // Operation codes carried by a request transaction
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_READ    = 2'd1,
    OP_ERASE   = 2'd2,
    OP_HAS_KEY = 2'd3
  } op_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEARCH,
    ST_ACT,
    ST_ERASE_RD,
    ST_ERASE_WR,
    ST_RESULT
  } state_t;

  // Status flags of one finished operation
  typedef struct packed {
    logic found;
    logic table_full;
  } res_flags_t;

endpackage

// ----- rtl/bkv_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bkv_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/bkv_ctrl.sv -----
// Sequencer, shared key comparator and fill counters of the key-value table.
`timescale 1ns / 1ps

module bkv_ctrl #(
  parameter int NUM_BINS      = 8,
  parameter int BIN_SLOTS     = 4,
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  bkv_pkg::op_t          op,
  input  logic [bkv_pkg::DATA_W-1:0] key,
  input  logic [bkv_pkg::DATA_W-1:0] val,
  input  logic                  out_free,
  output logic                  idle,
  output logic                  done,
  output bkv_pkg::res_flags_t   flags,
  output logic [bkv_pkg::DATA_W-1:0] rd_val,
  output logic [$clog2(NUM_BINS*BIN_SLOTS+TABLE_ENTRIES/2+1)-1:0] count,
  output logic                  ram_we,
  output logic [$clog2(NUM_BINS*BIN_SLOTS+TABLE_ENTRIES/2)-1:0] ram_waddr,
  output logic [2*bkv_pkg::DATA_W-1:0] ram_wdata,
  output logic [$clog2(NUM_BINS*BIN_SLOTS+TABLE_ENTRIES/2)-1:0] ram_raddr,
  input  logic [2*bkv_pkg::DATA_W-1:0] ram_rdata
);

  import bkv_pkg::*;

  localparam int OVF_SLOTS = TABLE_ENTRIES / 2;
  localparam int BIN_AREA  = NUM_BINS * BIN_SLOTS;
  localparam int DEPTH     = BIN_AREA + OVF_SLOTS;
  localparam int AW        = $clog2(DEPTH);
  localparam int CNT_W     = $clog2(DEPTH + 1);
  localparam int BB        = $clog2(NUM_BINS);
  localparam int BF_W      = $clog2(BIN_SLOTS + 1);
  localparam int OF_W      = $clog2(OVF_SLOTS + 1);
  localparam int MAXS      = (BIN_SLOTS > OVF_SLOTS) ? BIN_SLOTS : OVF_SLOTS;
  localparam int IW        = $clog2(MAXS + 1);

  state_t state, state_next;

  logic [BF_W-1:0]   bin_fill [NUM_BINS];
  logic [OF_W-1:0]   ovf_fill;
  logic              phase;          // 0 scanning the bin, 1 scanning overflow
  logic [IW-1:0]     idx;
  logic              pend;           // a read is in flight to the comparator
  logic              pend_phase;
  logic [IW-1:0]     pend_idx;
  logic              hit;
  logic              hit_phase;
  logic [IW-1:0]     hit_idx;
  logic [DATA_W-1:0] hit_val;
  logic              full;

  logic [BB-1:0]     bin;
  logic [BF_W-1:0]   cur_fill;
  logic [AW-1:0]     bbase;
  logic [IW-1:0]     limit;
  logic              issue;
  logic              hit_now;
  logic [AW-1:0]     hit_addr;
  logic              bin_has_room;
  logic              ovf_has_room;

  // Bin select and address arithmetic
  assign bin          = key[BB-1:0];
  assign cur_fill     = bin_fill[bin];
  assign bbase        = AW'(bin) * AW'(BIN_SLOTS);
  assign limit        = phase ? IW'(ovf_fill) : IW'(cur_fill);
  assign issue        = (state == ST_SEARCH) && (idx < limit);
  assign hit_now      = pend && (ram_rdata[2*DATA_W-1:DATA_W] == key);
  assign hit_addr     = hit_phase ? (AW'(BIN_AREA) + AW'(hit_idx)) : (bbase + AW'(hit_idx));
  assign bin_has_room = cur_fill < BF_W'(BIN_SLOTS);
  assign ovf_has_room = ovf_fill < OF_W'(OVF_SLOTS);

  assign idle  = (state == ST_IDLE);
  assign flags = '{found: hit, table_full: full};

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, RAM port control and done strobe
  always_comb begin
    state_next = state;
    ram_we     = 1'b0;
    ram_waddr  = hit_addr;
    ram_wdata  = {key, val};
    ram_raddr  = phase ? (AW'(BIN_AREA) + AW'(idx)) : (bbase + AW'(idx));
    done       = 1'b0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          state_next = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (hit_now) begin
          state_next = ST_ACT;
        end else if (!issue && phase && !pend) begin
          state_next = ST_ACT;
        end
      end
      ST_ACT: begin
        state_next = ST_RESULT;
        case (op)
          OP_WRITE: begin
            if (hit) begin
              ram_we = 1'b1;
            end else if (bin_has_room) begin
              ram_we    = 1'b1;
              ram_waddr = bbase + AW'(cur_fill);
            end else if (ovf_has_room) begin
              ram_we    = 1'b1;
              ram_waddr = AW'(BIN_AREA) + AW'(ovf_fill);
            end
          end
          OP_ERASE: begin
            if (hit) begin
              state_next = ST_ERASE_RD;
            end
          end
          default: begin
          end
        endcase
      end
      ST_ERASE_RD: begin
        // Fetch the last entry of the area that held the key
        ram_raddr  = hit_phase ? (AW'(BIN_AREA) + AW'(ovf_fill) - AW'(1))
                               : (bbase + AW'(cur_fill) - AW'(1));
        state_next = ST_ERASE_WR;
      end
      ST_ERASE_WR: begin
        // Move it into the hole
        ram_we     = 1'b1;
        ram_wdata  = ram_rdata;
        state_next = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) begin
          done       = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Search pipeline, hit capture, fill counters and key count
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 1'b0;
      idx   <= '0;
      pend  <= 1'b0;
      hit   <= 1'b0;
      full  <= 1'b0;
      ovf_fill <= '0;
      count <= '0;
      for (int i = 0; i < NUM_BINS; i++) begin
        bin_fill[i] <= '0;
      end
    end else begin
      case (state)
        ST_IDLE: begin
          if (start) begin
            phase  <= 1'b0;
            idx    <= '0;
            pend   <= 1'b0;
            hit    <= 1'b0;
            full   <= 1'b0;
            rd_val <= '1;
          end
        end
        ST_SEARCH: begin
          pend       <= issue && !hit_now;
          pend_phase <= phase;
          pend_idx   <= idx;
          if (hit_now) begin
            hit       <= 1'b1;
            hit_phase <= pend_phase;
            hit_idx   <= pend_idx;
            hit_val   <= ram_rdata[DATA_W-1:0];
          end else if (issue) begin
            idx <= idx + IW'(1);
          end else if (!phase) begin
            phase <= 1'b1;
            idx   <= '0;
          end
        end
        ST_ACT: begin
          case (op)
            OP_WRITE: begin
              if (!hit) begin
                if (bin_has_room) begin
                  bin_fill[bin] <= cur_fill + BF_W'(1);
                  count         <= count + CNT_W'(1);
                end else if (ovf_has_room) begin
                  ovf_fill <= ovf_fill + OF_W'(1);
                  count    <= count + CNT_W'(1);
                end else begin
                  full <= 1'b1;
                end
              end
            end
            OP_READ: begin
              if (hit) begin
                rd_val <= hit_val;
              end
            end
            default: begin
            end
          endcase
        end
        ST_ERASE_WR: begin
          if (hit_phase) begin
            ovf_fill <= ovf_fill - OF_W'(1);
          end else begin
            bin_fill[bin] <= cur_fill - BF_W'(1);
          end
          count <= count - CNT_W'(1);
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- rtl/binned_key_value_table_top.sv -----
// Top level of the binned key-value table: request capture, result register, store.
`timescale 1ns / 1ps

// Key-value table with NUM_BINS bins of BIN_SLOTS entries each and a shared
// overflow area of TABLE_ENTRIES/2 entries; a key's bin is its low
// log2(NUM_BINS) bits, so NUM_BINS must be a power of two. Operations are
// write (insert or update), read, erase and has_key; each request transaction
// yields exactly one response transaction with the value (all ones when not a
// read hit), found, table_full and the stored key count after the operation.
// One request is handled at a time. A single key comparator on the store's
// read port scans the key's bin and then the overflow area, one entry per
// cycle. A lookup that misses scans every stored entry of its bin and of the
// overflow area before it responds; a hit ends the scan as soon as the read
// data of its entry reaches the comparator, and an erase that hits then moves
// the last entry of its area into the hole. A response still held by the
// receiver holds the next result back. The block is idle again as soon as a
// response is registered and accepts the next request even while it waits.
// No clearing pass after reset is needed: fill counters gate every lookup.

module binned_key_value_table_top #(
  parameter int NUM_BINS      = 8,
  parameter int BIN_SLOTS     = 4,
  parameter int TABLE_ENTRIES = 64
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  bkv_pkg::op_t          operation,
  input  logic [bkv_pkg::DATA_W-1:0] lookup_key,
  input  logic [bkv_pkg::DATA_W-1:0] write_value,
  output logic                  rsp_valid,
  input  logic                  rsp_ready,
  output logic [bkv_pkg::DATA_W-1:0] read_value,
  output logic                  found,
  output logic                  table_full,
  output logic [$clog2(NUM_BINS*BIN_SLOTS+TABLE_ENTRIES/2+1)-1:0] occupancy
);

  import bkv_pkg::*;

  localparam int DEPTH = NUM_BINS * BIN_SLOTS + TABLE_ENTRIES / 2;
  localparam int AW    = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  op_t               op_q;
  logic [DATA_W-1:0] key_q;
  logic [DATA_W-1:0] val_q;

  logic               accept;
  logic               out_free;
  logic               idle;
  logic               done;
  res_flags_t         flags;
  logic [DATA_W-1:0]  rd_val;
  logic [CNT_W-1:0]   count;
  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [2*DATA_W-1:0] ram_wdata;
  logic [AW-1:0]      ram_raddr;
  logic [2*DATA_W-1:0] ram_rdata;

  assign req_ready = idle;
  assign accept    = req_valid && req_ready;
  assign out_free  = !rsp_valid || rsp_ready;

  // Request capture
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q  <= operation;
      key_q <= lookup_key;
      val_q <= write_value;
    end
  end

  // Response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (done) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      read_value <= rd_val;
      found      <= flags.found;
      table_full <= flags.table_full;
      occupancy  <= count;
    end
  end

  bkv_ctrl #(
    .NUM_BINS      (NUM_BINS),
    .BIN_SLOTS     (BIN_SLOTS),
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (accept),
    .op        (op_q),
    .key       (key_q),
    .val       (val_q),
    .out_free  (out_free),
    .idle      (idle),
    .done      (done),
    .flags     (flags),
    .rd_val    (rd_val),
    .count     (count),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

  // Key and value store, key in the upper half of each word
  bkv_ram #(
    .WIDTH (2 * DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Busy in the cycle after taking a request
  assert property (@(posedge clk) disable iff (rst) accept |=> !req_ready)
    else $error("request taken again right after acceptance");

  // A result is only produced when the response register can take it
  assert property (@(posedge clk) disable iff (rst) done |-> out_free)
    else $error("response overwritten before it was taken");

  // A dropped write never reports an existing key
  assert property (@(posedge clk) disable iff (rst) (rsp_valid && table_full) |-> !found)
    else $error("table_full together with found");

  // The key count never exceeds the store size
  assert property (@(posedge clk) disable iff (rst) count <= CNT_W'(DEPTH))
    else $error("key count beyond store size");

endmodule
